// File: src/ihc_pkg.sv
package ihc_pkg;

	localparam int MAX_PACKET_WORDS = 32768;
	localparam int IDX_W = 16;
	localparam logic [IDX_W-1:0] IDX_MAX = '1;
	localparam logic [IDX_W-1:0] IDX_LIMIT = IDX_W'(MAX_PACKET_WORDS - 1);

	localparam logic [15:0] SUM_OK = 16'hffff;
	localparam logic [31:0] ADDR_BCAST = 32'hffffffff;
	localparam logic [3:0] IP_VERSION = 4'd4;
	localparam logic [3:0] MIN_IHL = 4'd5;

	localparam logic [IDX_W-1:0] IDX_VER = IDX_W'(0);
	localparam logic [IDX_W-1:0] IDX_TTL = IDX_W'(4);
	localparam logic [IDX_W-1:0] IDX_DST_HI = IDX_W'(8);
	localparam logic [IDX_W-1:0] IDX_DST_LO = IDX_W'(9);

	localparam int IN_DATA_W = 24;
	localparam int OUT_DATA_W = 24;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_HEADER,
		MODE_PAYLOAD,
		MODE_DISCARD
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_VERSION = 3'd1,
		ST_HDR_LEN = 3'd2,
		ST_TTL = 3'd3,
		ST_CHECKSUM = 3'd4,
		ST_DEST = 3'd5,
		ST_TRUNC = 3'd6,
		ST_NONE = 3'd7
	} status_t;

	typedef struct packed {
		logic [15:0] word;
		logic first;
		logic last;
		logic [1:0] bytes;
	} in_beat_t;

	typedef struct packed {
		logic kind;
		status_t status;
		logic [15:0] word;
		logic [1:0] bytes;
		logic eop;
	} out_beat_t;

endpackage

// File: src/ihc_in_stage.sv
module ihc_in_stage (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input ihc_pkg::in_beat_t in_beat,
	output logic valid_s1,
	output ihc_pkg::in_beat_t beat_s1,
	input logic take
);
	import ihc_pkg::*;

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			beat_s1 <= in_beat;
		end
	end

endmodule

// File: src/ihc_check.sv
module ihc_check (
	input logic clk,
	input logic arst_n,
	input logic [31:0] local_address,
	input logic go,
	input ihc_pkg::in_beat_t beat,
	output logic res_valid,
	output ihc_pkg::out_beat_t res
);
	import ihc_pkg::*;

	mode_t mode_q, mode_e, mode_n;
	logic [IDX_W-1:0] idx_q, idx_e, idx_n;
	logic [4:0] hw_q, hw_e, hw_n;
	logic [15:0] sum_q, sum_e, sum_n;
	logic [31:0] dest_q, dest_e, dest_n;
	logic [16:0] sum_wide;
	logic full;
	logic at_limit;
	status_t st;

	always_comb begin
		full = beat.bytes != 2'd1;
		if (beat.first) begin
			mode_e = MODE_HEADER;
			idx_e = '0;
			hw_e = '0;
			sum_e = '0;
			dest_e = '0;
		end else begin
			mode_e = mode_q;
			idx_e = idx_q;
			hw_e = hw_q;
			sum_e = sum_q;
			dest_e = dest_q;
		end
		sum_wide = {1'b0, sum_e} + {1'b0, beat.word};
		at_limit = idx_e >= IDX_LIMIT;

		mode_n = mode_e;
		idx_n = (idx_e != IDX_MAX) ? idx_e + 1'b1 : idx_e;
		hw_n = hw_e;
		sum_n = sum_e;
		dest_n = dest_e;
		st = ST_NONE;
		res_valid = 1'b0;
		res = '{kind: 1'b0, status: ST_OK, word: '0, bytes: '0, eop: 1'b0};

		unique case (mode_e)
			MODE_IDLE: begin
				idx_n = idx_q;
			end
			MODE_DISCARD: begin
				if (beat.last) begin
					mode_n = MODE_IDLE;
				end
			end
			MODE_PAYLOAD: begin
				res_valid = 1'b1;
				res.kind = 1'b1;
				res.word = beat.word;
				res.bytes = full ? 2'd2 : 2'd1;
				res.eop = beat.last || at_limit;
				if (beat.last) begin
					mode_n = MODE_IDLE;
				end else if (at_limit) begin
					mode_n = MODE_DISCARD;
				end
			end
			MODE_HEADER: begin
				if (!full) begin
					st = ST_TRUNC;
				end else begin
					sum_n = sum_wide[15:0] + {15'd0, sum_wide[16]};
					if (idx_e == IDX_VER) begin
						if (beat.word[15:12] != IP_VERSION) begin
							st = ST_VERSION;
						end else if (beat.word[11:8] < MIN_IHL) begin
							st = ST_HDR_LEN;
						end else begin
							hw_n = {beat.word[11:8], 1'b0};
						end
					end else if (idx_e == IDX_TTL) begin
						if (beat.word[15:8] == 8'd0) begin
							st = ST_TTL;
						end
					end else if (idx_e == IDX_DST_HI) begin
						dest_n = {beat.word, 16'd0};
					end else if (idx_e == IDX_DST_LO) begin
						dest_n = {dest_e[31:16], beat.word};
					end
					if (st == ST_NONE && hw_n != '0
							&& idx_e == IDX_W'(hw_n - 5'd1)) begin
						if (sum_n != SUM_OK) begin
							st = ST_CHECKSUM;
						end else if (dest_n != local_address && dest_n != ADDR_BCAST) begin
							st = ST_DEST;
						end else begin
							st = ST_OK;
						end
					end
				end
				if (st == ST_NONE && beat.last) begin
					st = ST_TRUNC;
				end
				if (st != ST_NONE) begin
					res_valid = 1'b1;
					res.status = st;
					if (st == ST_OK && !beat.last) begin
						mode_n = MODE_PAYLOAD;
					end else begin
						res.eop = 1'b1;
						mode_n = beat.last ? MODE_IDLE : MODE_DISCARD;
					end
				end
			end
			default: ;
		endcase
		res_valid = res_valid && go;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			idx_q <= '0;
			hw_q <= '0;
			sum_q <= '0;
			dest_q <= '0;
		end else if (go) begin
			mode_q <= mode_n;
			idx_q <= idx_n;
			hw_q <= hw_n;
			sum_q <= sum_n;
			dest_q <= dest_n;
		end
	end

endmodule

// File: src/ihc_out_stage.sv
module ihc_out_stage (
	input logic clk,
	input logic arst_n,
	input logic load,
	input ihc_pkg::out_beat_t res,
	output logic free,
	output logic out_valid,
	input logic out_ready,
	output ihc_pkg::out_beat_t out_beat
);
	import ihc_pkg::*;

	logic valid_q;

	assign free = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			out_beat <= res;
		end
	end

endmodule

// File: src/ipv4_header_check.sv
// IPv4 receive header check.
// Slave stream: one 16-bit packet word per beat, network byte order.
//   s_tuser marks the first word of a packet, s_tlast the last word,
//   s_tdata carries the word and its valid byte count (1 only on last).
// Master stream: one verdict beat per packet (m_tuser 0) with a status code
//   (0 ok, 1 version, 2 header length, 3 ttl, 4 checksum, 5 destination,
//   6 truncated), then, for accepted packets, each payload word up to word index 32767 (m_tuser 1).
//   m_tlast marks the final beat produced for a packet.
// cfg_we/cfg_data load the local address; broadcast is always accepted.
//   Write it only while no beat is in flight.
// A result beat passes from the input register through the check logic into
//   the output register, which drives m_tvalid.
// Throughput: one beat per cycle sustained while m_tready is high, set by the
//   single pass of the check logic between the two registers.
// Reset clears the packet state to idle and the local address to zero;
//   no beats are held. When m_tready is low the output register holds its
//   beat and s_tready drops once the input register is also occupied.
module ipv4_header_check (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [31:0] cfg_data,
	input logic s_tvalid,
	output logic s_tready,
	input logic [23:0] s_tdata,   // packet_word[15:0], word_bytes[17:16], zero fill
	input logic s_tuser,          // first_word
	input logic s_tlast,
	output logic m_tvalid,
	input logic m_tready,
	output logic [23:0] m_tdata,  // status[2:0], payload_word[18:3], payload_bytes[20:19], zero
	output logic m_tuser,         // item_kind
	output logic m_tlast
);
	import ihc_pkg::*;

	logic [31:0] local_address_q;
	in_beat_t in_beat, beat_s1;
	out_beat_t res, out_beat;
	logic valid_s1, take, res_valid, free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_address_q <= '0;
		end else if (cfg_we) begin
			local_address_q <= cfg_data;
		end
	end

	assign in_beat = '{word: s_tdata[15:0], first: s_tuser, last: s_tlast,
		bytes: s_tdata[17:16]};
	assign take = valid_s1 && free;

	ihc_in_stage u_in (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_beat(in_beat),
		.valid_s1(valid_s1),
		.beat_s1(beat_s1),
		.take(take)
	);

	ihc_check u_check (
		.clk(clk),
		.arst_n(arst_n),
		.local_address(local_address_q),
		.go(take),
		.beat(beat_s1),
		.res_valid(res_valid),
		.res(res)
	);

	ihc_out_stage u_out (
		.clk(clk),
		.arst_n(arst_n),
		.load(res_valid),
		.res(res),
		.free(free),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_beat(out_beat)
	);

	assign m_tdata = {3'd0, out_beat.bytes, out_beat.word, out_beat.status};
	assign m_tuser = out_beat.kind;
	assign m_tlast = out_beat.eop;

endmodule
